/* rtl/umts_pkg.sv */
`timescale 1ns / 1ps
// umts_pkg: shared widths and constants for the monotonic timestamp sequencer.
// No dependencies.
package umts_pkg;

  localparam int unsigned TICK_W   = 57;
  localparam int unsigned ISSUED_W = 58;
  localparam int unsigned TS_W     = 60;
  localparam int unsigned GRAN_W   = 20;
  localparam int unsigned SEQ_W    = 14;
  localparam int unsigned SEED_W   = 13;
  localparam int unsigned FRAC_W   = 12;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_GRANULARITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 2'd1;

  // 100 ns ticks between the Gregorian and Unix epochs
  localparam logic [TS_W-1:0] GREG_OFFSET = 60'h01B_21DD_2138_14000;

  localparam logic [GRAN_W-1:0] US_PER_MS   = 20'd1000;
  localparam logic [21:0]       ROUND_HALF  = 22'd500;
  localparam logic [CNT_W-1:0]  DIV_STEPS   = 6'd58;
  localparam logic [CNT_W-1:0]  FRAC_STEPS  = 6'd22;

endpackage

/* rtl/uuid_monotonic_timestamp_sequencer_core.sv */
`timescale 1ns / 1ps
// uuid_monotonic_timestamp_sequencer_core: monotonic v6/v7 UUID timestamp issue.
// Depends on umts_pkg.
//
//  channel  direction  handshake              payload
//  -------  ---------  ---------------------  --------------------------------------------
//  in       sink       in_valid / in_stall    time_now, retry_after_wait, random_seed
//  out      source     out_valid / out_stall  success, timestamp, sub_ms_fraction,
//                                             sequence_res
//  cfg      sink       cfg_write              cfg_index, cfg_data (no read-back)
//
// Flow: one shared restoring divider retires one quotient bit per cycle and sets the
//   rate. An accepted request runs the granularity pass (only when granularity is
//   nonzero), update and sum, then the Gregorian offset in mode 0 or the ms split and
//   fraction passes in mode 1, and emit. A refused request goes from update to emit.
// Reset: synchronous, active high; clears the config registers, sequencer state and out_valid.
// Stalls: in_stall is high while a request is in work; a finished result waits in the
//   output register under out_stall while the next request is accepted and processed.
module uuid_monotonic_timestamp_sequencer_core
  import umts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GRAN_W-1:0]    cfg_data,
  // request
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TICK_W-1:0]    time_now,
  input  logic                 retry_after_wait,
  input  logic [SEED_W-1:0]    random_seed,
  // result
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 success,
  output logic [TS_W-1:0]      timestamp,
  output logic [FRAC_W-1:0]    sub_ms_fraction,
  output logic [SEQ_W-1:0]     sequence_res
);

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a request
    ST_GDIV,    // reading mod granularity, bit serial
    ST_UPDATE,  // compare with last tick, step the sequencer
    ST_SUM,     // issued = last tick + adjustment
    ST_OFFS,    // mode 0: add Gregorian offset
    ST_MDIV,    // mode 1: issued / 1000, bit serial
    ST_FDIV,    // mode 1: rounded fraction, bit serial
    ST_EMIT     // hand over to the output register
  } state_t;

  state_t state;

  // configuration registers
  logic [GRAN_W-1:0] granularity;
  logic              output_mode;

  // sequencer state
  logic [TICK_W-1:0] last_tick;
  logic [GRAN_W-1:0] adjustment;
  logic [SEQ_W-1:0]  seq_counter;
  logic              started;

  // per-request working registers
  logic [TICK_W-1:0]   tick;
  logic                retry;
  logic [SEED_W-1:0]   seed;
  logic                ok;
  logic [TS_W-1:0]     ts_work;
  logic [FRAC_W-1:0]   frac_work;

  // shared divider: dividend shifts out MSB first, quotient bits shift in at the LSB
  logic [ISSUED_W-1:0] dividend;
  logic [GRAN_W-1:0]   divisor;
  logic [GRAN_W-1:0]   rem;
  logic [CNT_W-1:0]    cnt;

  logic [GRAN_W:0]     trial;
  logic                trial_ge;
  logic [GRAN_W-1:0]   rem_step;
  logic [ISSUED_W-1:0] dividend_step;
  logic                last_step;

  always_comb begin
    trial         = {rem, dividend[ISSUED_W-1]};
    trial_ge      = (trial >= {1'b0, divisor});
    rem_step      = trial_ge ? GRAN_W'(trial - {1'b0, divisor}) : trial[GRAN_W-1:0];
    dividend_step = {dividend[ISSUED_W-2:0], trial_ge};
    last_step     = (cnt == CNT_W'(1));
  end

  // sequencer decisions
  logic              tick_lt, tick_eq, adj_spent, seq_exhausted;
  logic [SEQ_W-1:0]  seq_inc;
  logic [21:0]       frac_dividend;

  always_comb begin
    tick_lt   = (tick < last_tick);
    tick_eq   = (tick == last_tick);
    adj_spent = (adjustment >= granularity);
    seq_inc   = seq_counter + SEQ_W'(1);
    // same tick, adjustment used up and the sequence would wrap: refuse
    seq_exhausted = started && tick_eq && adj_spent && (seq_inc == '0);
    // (rem * 4096 + 500) / 1000 gives the half-up rounded fraction
    frac_dividend = {rem_step[9:0], 12'b0} + ROUND_HALF;
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      granularity <= '0;
      output_mode <= 1'b0;
      last_tick   <= '0;
      adjustment  <= '0;
      seq_counter <= '0;
      started     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRANULARITY: granularity <= cfg_data;
          REG_OUTPUT_MODE: output_mode <= cfg_data[0];
          default: ;
        endcase
      end

      // emit reloads the register itself when the old result leaves
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            tick     <= time_now;
            retry    <= retry_after_wait;
            seed     <= random_seed;
            dividend <= {1'b0, time_now};
            divisor  <= granularity;
            rem      <= '0;
            cnt      <= DIV_STEPS;
            state    <= (granularity != '0) ? ST_GDIV : ST_UPDATE;
          end
        end

        ST_GDIV: begin
          dividend <= dividend_step;
          rem      <= rem_step;
          cnt      <= cnt - CNT_W'(1);
          if (last_step) begin
            // truncate down to a multiple of granularity
            tick  <= tick - {{(TICK_W-GRAN_W){1'b0}}, rem_step};
            state <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          ok    <= !seq_exhausted;
          state <= seq_exhausted ? ST_EMIT : ST_SUM;
          if (!started || tick_lt) begin
            started     <= 1'b1;
            seq_counter <= {1'b0, seed};
            adjustment  <= '0;
            last_tick   <= tick;
          end else if (tick_eq) begin
            if (adj_spent) begin
              if (seq_exhausted) begin
                // sequence exhausted: state left alone
                ts_work   <= '0;
                frac_work <= '0;
              end else begin
                seq_counter <= seq_inc;
              end
            end else begin
              adjustment <= adjustment + GRAN_W'(1);
            end
          end else begin
            adjustment <= '0;
            last_tick  <= tick;
            if (retry) begin
              seq_counter <= {1'b0, seed};
            end
          end
        end

        ST_SUM: begin
          dividend <= {1'b0, last_tick} + {{(ISSUED_W-GRAN_W){1'b0}}, adjustment};
          divisor  <= US_PER_MS;
          rem      <= '0;
          cnt      <= DIV_STEPS;
          state    <= output_mode ? ST_MDIV : ST_OFFS;
        end

        ST_OFFS: begin
          ts_work   <= {{(TS_W-ISSUED_W){1'b0}}, dividend} + GREG_OFFSET;
          frac_work <= '0;
          state     <= ST_EMIT;
        end

        ST_MDIV: begin
          if (last_step) begin
            ts_work  <= {{(TS_W-ISSUED_W){1'b0}}, dividend_step};
            // left-justify the 22-bit fraction dividend for the next pass
            dividend <= {frac_dividend, {(ISSUED_W-22){1'b0}}};
            rem      <= '0;
            cnt      <= FRAC_STEPS;
            state    <= ST_FDIV;
          end else begin
            dividend <= dividend_step;
            rem      <= rem_step;
            cnt      <= cnt - CNT_W'(1);
          end
        end

        ST_FDIV: begin
          dividend <= dividend_step;
          rem      <= rem_step;
          cnt      <= cnt - CNT_W'(1);
          if (last_step) begin
            frac_work <= dividend_step[FRAC_W-1:0];
            state     <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            success         <= ok;
            timestamp       <= ts_work;
            sub_ms_fraction <= frac_work;
            sequence_res    <= ok ? seq_counter : '0;
            state           <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // a failed request carries all-zero result fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !success |-> (timestamp == '0) && (sequence_res == '0)
                              && (sub_ms_fraction == '0))
    else $error("failed request with nonzero result fields");

  // mode 0 results never carry a fraction
  a_mode0_frac: assert property (@(posedge clk) disable iff (rst)
    out_valid && !output_mode |-> sub_ms_fraction == '0)
    else $error("fraction set in mode 0");

  // a new result only comes out of the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result loaded outside emit");

  // divider never runs with a spent step count
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GDIV || state == ST_MDIV || state == ST_FDIV) |-> cnt != '0)
    else $error("divider step count exhausted");

  // once seeded, the sequencer stays seeded
  a_started: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started flag dropped");

endmodule

/* dv/umts_stamp_checker.sv */
`timescale 1ns / 1ps
// umts_stamp_checker: predicts each issued timestamp and compares it with the core's result.
// Depends on umts_pkg; watches the cfg, request and result channels of the core.
module umts_stamp_checker
  import umts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GRAN_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [TICK_W-1:0]    time_now,
  input  logic                 retry_after_wait,
  input  logic [SEED_W-1:0]    random_seed,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 success,
  input  logic [TS_W-1:0]      timestamp,
  input  logic [FRAC_W-1:0]    sub_ms_fraction,
  input  logic [SEQ_W-1:0]     sequence_res,
  output int                   mismatches,
  output int                   stamps_owed
);

  typedef struct packed {
    logic              ok;
    logic [TS_W-1:0]   ts;
    logic [FRAC_W-1:0] frac;
    logic [SEQ_W-1:0]  seq;
  } stamp_t;

  localparam logic [63:0] FRAC_SCALE = 64'd1 << FRAC_W;

  // shadow registers and sequencer state
  logic [GRAN_W-1:0] gran_q;
  logic              mode_q;
  logic [TICK_W-1:0] last_tick_q;
  logic [GRAN_W-1:0] adj_q;
  logic [SEQ_W-1:0]  seq_q;
  logic              started_q;
  stamp_t            owed_q[$];

  function automatic stamp_t issue_stamp(input logic [TICK_W-1:0] now, input logic retry,
                                         input logic [SEED_W-1:0] seed);
    logic [63:0]      tick;
    logic [63:0]      issued;
    logic [63:0]      rem;
    logic [63:0]      scaled;
    logic [SEQ_W-1:0] bumped;
    stamp_t           s;
    s    = '0;
    tick = 64'(now);
    if (gran_q != '0) tick = (tick / 64'(gran_q)) * 64'(gran_q);
    if (!started_q || tick < 64'(last_tick_q)) begin
      started_q   = 1'b1;
      seq_q       = SEQ_W'(seed);
      adj_q       = '0;
      last_tick_q = tick[TICK_W-1:0];
    end else if (tick == 64'(last_tick_q)) begin
      if (adj_q >= gran_q) begin
        bumped = seq_q + 1'b1;
        if (bumped == '0) return s;   // sequence exhausted, state kept
        seq_q = bumped;
      end else begin
        adj_q = adj_q + 1'b1;
      end
    end else begin
      adj_q       = '0;
      last_tick_q = tick[TICK_W-1:0];
      if (retry) seq_q = SEQ_W'(seed);
    end
    issued = 64'(last_tick_q) + 64'(adj_q);
    s.ok   = 1'b1;
    if (!mode_q) begin
      s.ts = TS_W'(issued + 64'(GREG_OFFSET));
    end else begin
      rem    = issued % 64'(US_PER_MS);
      scaled = rem * FRAC_SCALE;
      s.ts   = TS_W'(issued / 64'(US_PER_MS));
      s.frac = FRAC_W'(scaled / 64'(US_PER_MS) +
                       ((scaled % 64'(US_PER_MS)) >= 64'(ROUND_HALF) ? 64'd1 : 64'd0));
    end
    s.seq = seq_q;
    return s;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    stamp_t want;
    if (rst) begin
      gran_q      = '0;
      mode_q      = 1'b0;
      last_tick_q = '0;
      adj_q       = '0;
      seq_q       = '0;
      started_q   = 1'b0;
      owed_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRANULARITY: gran_q = cfg_data;
          REG_OUTPUT_MODE: mode_q = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual success %0b timestamp 0x%0h",
                   $time, success, timestamp);
        end else begin
          want = owed_q.pop_front();
          check_field("success", 64'(want.ok), 64'(success));
          check_field("timestamp", 64'(want.ts), 64'(timestamp));
          check_field("sub_ms_fraction", 64'(want.frac), 64'(sub_ms_fraction));
          check_field("sequence_res", 64'(want.seq), 64'(sequence_res));
        end
      end
      if (in_valid && !in_stall)
        owed_q.push_back(issue_stamp(time_now, retry_after_wait, random_seed));
    end
    stamps_owed = owed_q.size();
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// tb: stimulus and verdict for uuid_monotonic_timestamp_sequencer_core.
// Depends on umts_pkg, the core and umts_stamp_checker.
module tb;
  import umts_pkg::*;

  // register indexes past the map; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [TICK_W-1:0]    TICK_MAX     = '1;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int PHASES         = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 160;
  localparam int SEQ_SPAN       = 1 << SEQ_W;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GRAN_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [TICK_W-1:0]    time_now;
  logic                 retry_after_wait;
  logic [SEED_W-1:0]    random_seed;
  logic                 out_valid;
  logic                 out_stall;
  logic                 success;
  logic [TS_W-1:0]      timestamp;
  logic [FRAC_W-1:0]    sub_ms_fraction;
  logic [SEQ_W-1:0]     sequence_res;

  int                mismatches;
  int                stamps_owed;
  int                quiet_cycles;
  logic              calm;           // 1 = neither side idles
  logic [TICK_W-1:0] clock_reading;  // last reading sent, base for the next one

  uuid_monotonic_timestamp_sequencer_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .time_now         (time_now),
    .retry_after_wait (retry_after_wait),
    .random_seed      (random_seed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .success          (success),
    .timestamp        (timestamp),
    .sub_ms_fraction  (sub_ms_fraction),
    .sequence_res     (sequence_res)
  );

  umts_stamp_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .time_now         (time_now),
    .retry_after_wait (retry_after_wait),
    .random_seed      (random_seed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .success          (success),
    .timestamp        (timestamp),
    .sub_ms_fraction  (sub_ms_fraction),
    .sequence_res     (sequence_res),
    .mismatches       (mismatches),
    .stamps_owed      (stamps_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, changed only on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 11);
    end
  end

  // Watchdog: any request, result or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Offers one request and returns at the rising edge that accepts it.
  // Random idle cycles go in front, so gaps land on every phase of the core's work.
  task automatic send_request(input logic [TICK_W-1:0] t, input logic retry,
                              input logic [SEED_W-1:0] seed);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    time_now         <= t;
    retry_after_wait <= retry;
    random_seed      <= seed;
    clock_reading     = t;
    do @(posedge clk); while (in_stall);
  endtask

  // Drops valid, then holds off until every issued request has its result back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (stamps_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GRAN_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Mode register takes random upper bits; only bit 0 counts.
  // Spare indexes get random data that must not land anywhere.
  task automatic set_config(input logic [GRAN_W-1:0] gran, input logic mode);
    write_reg(REG_GRANULARITY, gran);
    write_reg(REG_SPARE_LO, GRAN_W'($urandom));
    write_reg(REG_OUTPUT_MODE, (GRAN_W'($urandom) & ~GRAN_W'(1)) | GRAN_W'(mode));
    write_reg(REG_SPARE_HI, GRAN_W'($urandom));
  endtask

  // Readings mostly stand still or creep, so the adjustment and the sequence get
  // exercised; the rest jump forward, step back, land anywhere, or sit at the top.
  function automatic logic [TICK_W-1:0] next_reading();
    int                pick;
    logic [TICK_W-1:0] r;
    pick = $urandom_range(99);
    r    = clock_reading;
    if (pick < 40)      r = clock_reading;
    else if (pick < 60) r = clock_reading + TICK_W'($urandom_range(3));
    else if (pick < 75) r = clock_reading + TICK_W'($urandom_range(2000000));
    else if (pick < 85) r = (clock_reading > 2000) ?
                            clock_reading - TICK_W'($urandom_range(2000)) : '0;
    else if (pick < 95) r = TICK_W'({$urandom, $urandom});
    else                r = TICK_MAX - TICK_W'($urandom_range(3));
    return r;
  endfunction

  function automatic logic [GRAN_W-1:0] phase_gran(input int p);
    case (p)
      0:       return GRAN_W'(0);
      1:       return GRAN_W'(1);
      2:       return GRAN_W'(3);
      3:       return GRAN_W'(1000);
      4:       return GRAN_W'(1000000);
      5:       return GRAN_W'(7);
      6:       return GRAN_W'(2);
      default: return GRAN_W'(999999);
    endcase
  endfunction

  initial begin
    logic [TICK_W-1:0] hold_t;
    int                wrap_seed;
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    time_now         = '0;
    retry_after_wait = 1'b0;
    random_seed      = '0;
    calm             = 1'b0;
    clock_reading    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed: reset config is granularity 0, mode 0 ----
    send_request('0, 1'b0, 13'h1FFF);          // first request seeds
    send_request('0, 1'b1, 13'h0000);          // same time, no granularity: sequence bumps
    send_request(TICK_MAX, 1'b0, 13'h0005);    // forward without retry keeps the sequence
    send_request(TICK_MAX, 1'b1, 13'h0007);    // same time again at the top reading
    send_request(57'd5, 1'b0, 13'h1555);       // backward: reseed
    send_request(57'd6, 1'b1, 13'h0AAA);       // forward with retry: reseed
    wait_drained();

    // granularity 5 in ms mode: adjustment climbs while the tick stands
    set_config(20'd5, 1'b1);
    send_request(57'd1000, 1'b0, 13'h0123);
    send_request(57'd1003, 1'b0, 13'h0456);
    send_request(57'd1004, 1'b1, 13'h0789);
    send_request(57'd1001, 1'b0, 13'h0ABC);
    wait_drained();

    // granularity lowered under the held adjustment: counts as spent, so the sequence bumps
    write_reg(REG_GRANULARITY, 20'd2);
    send_request(57'd1000, 1'b0, 13'h1234);
    wait_drained();

    // widest granularity, all-ones mode data
    write_reg(REG_GRANULARITY, 20'd1000000);
    write_reg(REG_OUTPUT_MODE, 20'hFFFFF);
    send_request(TICK_MAX, 1'b1, 13'h1FFF);
    send_request(TICK_MAX - 57'd1, 1'b0, 13'h0000);
    wait_drained();

    // fraction rounding: remainders 999, 500 and 1
    write_reg(REG_GRANULARITY, 20'd0);
    send_request(57'd999, 1'b1, 13'h0F0F);
    send_request(57'd1500, 1'b0, 13'h10F0);
    send_request(57'd1, 1'b1, 13'h0001);
    wait_drained();

    // back to Gregorian mode through masked write data, top reading
    write_reg(REG_OUTPUT_MODE, 20'hFFFFE);
    send_request(TICK_MAX, 1'b1, 13'h1FFF);
    wait_drained();

    // ---- random phases across granularity and mode settings ----
    for (int p = 0; p < PHASES; p++) begin
      set_config(phase_gran(p), p[0]);
      calm = (p == 2);                         // one long stretch with no idling
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        send_request(next_reading(), 1'($urandom_range(1)), SEED_W'($urandom));
        if (p == 4 && i == 90) wait_drained(); // sender holds off mid-phase
      end
      wait_drained();
    end

    // ---- sequence exhaustion: hold one reading until the 14-bit sequence wraps ----
    calm = 1'b1;
    set_config(20'd0, 1'b0);
    hold_t = TICK_W'({$urandom, $urandom});
    if (hold_t == TICK_MAX) hold_t = '0;
    wrap_seed = $urandom_range(8191, 8000);
    send_request(TICK_MAX, 1'b0, SEED_W'($urandom));
    send_request(hold_t, 1'b0, SEED_W'(wrap_seed));   // always backward: reseeds
    // bumps up to the top value, then three refused requests
    for (int i = 0; i < SEQ_SPAN + 2 - wrap_seed; i++)
      send_request(hold_t, 1'b0, SEED_W'($urandom));
    send_request(hold_t + 57'd1, 1'b1, SEED_W'($urandom));  // newer reading with retry
    wait_drained();
    calm = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
